[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[src/onenc_pkg.sv]
// ----------------------------------------------------------------------------
// Octahedral encoder package
// Control group that travels alongside the data through the pipeline.
// ----------------------------------------------------------------------------
package onenc_pkg;

  typedef struct packed {
    logic valid;
    logic zero;
  } onenc_ctl_t;

endpackage

[src/octahedral_normal_encode_top.sv]
// ----------------------------------------------------------------------------
// Octahedral normal encoder
// Fully pipelined fixed-point octahedral encoding of a direction vector.
// ----------------------------------------------------------------------------
// The block takes one vector in every clock cycle and returns its two
// octahedral codes, one result per transaction, in order. The pipeline is
// made of three front stages (magnitudes, L1 sum and folding, dividend
// forming), one restoring-division stage per output bit, and the output
// register. Busy is never raised, so start may be held high
// continuously; the result strobe out_valid is high for exactly one cycle per
// transaction and the receiver cannot stall it. A vector whose components are
// all zero returns the midpoint code on both outputs with out_zero_vector set.
`include "assert_macros.svh"

module octahedral_normal_encode_top #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [IN_BITS-1:0] in_vec_x,
  input  logic signed [IN_BITS-1:0] in_vec_y,
  input  logic signed [IN_BITS-1:0] in_vec_z,
  output logic                      out_valid,
  output logic [OUT_BITS-1:0]       out_enc_u,
  output logic [OUT_BITS-1:0]       out_enc_v,
  output logic                      out_zero_vector
);

  // Sum width, divisor width (2s) and dividend width.
  localparam int SW  = IN_BITS + 2;
  localparam int DW  = SW + 1;
  localparam int TW  = SW + OUT_BITS + 2;
  localparam int LAT = OUT_BITS + 4;
  localparam logic [OUT_BITS-1:0] MID = OUT_BITS'(1) << (OUT_BITS - 1);

  // Every transaction is taken; the pipeline never holds back.
  assign busy = 1'b0;

  onenc_pkg::onenc_ctl_t ctl   [0:OUT_BITS];
  logic [TW-1:0]         rem_u [0:OUT_BITS];
  logic [TW-1:0]         rem_v [0:OUT_BITS];
  logic [OUT_BITS-1:0]   q_u   [0:OUT_BITS];
  logic [OUT_BITS-1:0]   q_v   [0:OUT_BITS];
  logic [DW-1:0]         den   [0:OUT_BITS];

  onenc_front #(
    .IN_BITS  (IN_BITS),
    .OUT_BITS (OUT_BITS),
    .SW       (SW),
    .DW       (DW),
    .TW       (TW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .vec_x    (in_vec_x),
    .vec_y    (in_vec_y),
    .vec_z    (in_vec_z),
    .ctl_o    (ctl[0]),
    .top_u_o  (rem_u[0]),
    .top_v_o  (rem_v[0]),
    .den_o    (den[0])
  );

  assign q_u[0] = '0;
  assign q_v[0] = '0;

  // One quotient bit per stage, most significant first. The quotient never
  // exceeds 2^OUT_BITS - 1, so no saturation is required.
  for (genvar k = 0; k < OUT_BITS; k++) begin : g_div
    onenc_div_stage #(
      .TW  (TW),
      .DW  (DW),
      .QW  (OUT_BITS),
      .BIT (OUT_BITS - 1 - k)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl[k]),
      .rem_u_i (rem_u[k]),
      .rem_v_i (rem_v[k]),
      .q_u_i   (q_u[k]),
      .q_v_i   (q_v[k]),
      .den_i   (den[k]),
      .ctl_o   (ctl[k+1]),
      .rem_u_o (rem_u[k+1]),
      .rem_v_o (rem_v[k+1]),
      .q_u_o   (q_u[k+1]),
      .q_v_o   (q_v[k+1]),
      .den_o   (den[k+1])
    );
  end

  // Output register. For a zero vector the divisor is zero and the quotient
  // is meaningless, so the midpoint code replaces it.
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_enc_u_r, out_enc_v_r;
  logic                out_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl[OUT_BITS].valid;
    end
    out_zero_r  <= ctl[OUT_BITS].zero;
    out_enc_u_r <= ctl[OUT_BITS].zero ? MID : q_u[OUT_BITS];
    out_enc_v_r <= ctl[OUT_BITS].zero ? MID : q_v[OUT_BITS];
  end

  assign out_valid       = out_valid_r;
  assign out_enc_u       = out_enc_u_r;
  assign out_enc_v       = out_enc_v_r;
  assign out_zero_vector = out_zero_r;

  // Helper terms that keep the assertions short.
  logic in_all_zero;
  logic out_is_mid;

  assign in_all_zero = (in_vec_x == '0) && (in_vec_y == '0) && (in_vec_z == '0);
  assign out_is_mid  = (out_enc_u == MID) && (out_enc_v == MID);

  // Every accepted transaction produces a result at the output.
  `ASSERT_CLK(a_latency, clk, rst_n, start |-> ##LAT out_valid)
  // A zero vector entering is flagged at the output.
  `ASSERT_CLK(a_zero_flag, clk, rst_n, (start && in_all_zero) |-> ##LAT out_zero_vector)
  // Flagged results carry the midpoint code on both outputs.
  `ASSERT_CLK(a_zero_mid, clk, rst_n, (out_valid && out_zero_vector) |-> out_is_mid)
  // No result appears without a corresponding earlier transaction.
  `ASSERT_CLK(a_no_phantom, clk, rst_n, (out_valid && $past(rst_n, LAT)) |-> $past(start, LAT))

endmodule

[src/onenc_front.sv]
// ----------------------------------------------------------------------------
// Octahedral encoder front end
// Three stages: magnitudes, L1 sum with folded numerators, dividends.
// ----------------------------------------------------------------------------
module onenc_front #(
  parameter int IN_BITS  = 16,
  parameter int OUT_BITS = 16,
  parameter int SW       = IN_BITS + 2,
  parameter int DW       = SW + 1,
  parameter int TW       = SW + OUT_BITS + 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic signed [IN_BITS-1:0] vec_x,
  input  logic signed [IN_BITS-1:0] vec_y,
  input  logic signed [IN_BITS-1:0] vec_z,
  output onenc_pkg::onenc_ctl_t     ctl_o,
  output logic [TW-1:0]             top_u_o,
  output logic [TW-1:0]             top_v_o,
  output logic [DW-1:0]             den_o
);

  localparam int PW = SW + 1;

  // Stage one: magnitudes and signs.
  logic               v1_r;
  logic [IN_BITS-1:0] ax_r, ay_r, az_r;
  logic               sx_r, sy_r, zpos_r;

  // Stage two: sum and shifted numerators (num + s).
  logic               v2_r, zero2_r;
  logic [SW-1:0]      s2_r;
  logic [PW-1:0]      pu_r, pv_r;
  logic [SW-1:0]      s_nxt;
  logic [PW-1:0]      pu_nxt, pv_nxt;

  // Stage three: dividends and divisor.
  onenc_pkg::onenc_ctl_t ctl3_r;
  logic [TW-1:0]      tu_r, tv_r;
  logic [DW-1:0]      d_r;

  function automatic logic [IN_BITS-1:0] mag(input logic signed [IN_BITS-1:0] a);
    mag = a[IN_BITS-1] ? IN_BITS'(-a) : IN_BITS'(a);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    ax_r   <= mag(vec_x);
    ay_r   <= mag(vec_y);
    az_r   <= mag(vec_z);
    sx_r   <= vec_x[IN_BITS-1];
    sy_r   <= vec_y[IN_BITS-1];
    zpos_r <= !vec_z[IN_BITS-1] && (vec_z != '0);
  end

  always_comb begin
    s_nxt = SW'(ax_r) + SW'(ay_r) + SW'(az_r);
    if (zpos_r) begin
      pu_nxt = sx_r ? PW'(s_nxt - SW'(ax_r)) : PW'(s_nxt) + PW'(ax_r);
      pv_nxt = sy_r ? PW'(s_nxt - SW'(ay_r)) : PW'(s_nxt) + PW'(ay_r);
    end else begin
      pu_nxt = sx_r ? PW'(ay_r) : {s_nxt, 1'b0} - PW'(ay_r);
      pv_nxt = sy_r ? PW'(ax_r) : {s_nxt, 1'b0} - PW'(ax_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    zero2_r <= (s_nxt == '0);
    s2_r    <= s_nxt;
    pu_r    <= pu_nxt;
    pv_r    <= pv_nxt;
  end

  // (num + s) * (2^OUT_BITS - 1) + s, done as shift and subtract.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r.valid <= 1'b0;
    end else begin
      ctl3_r.valid <= v2_r;
    end
    ctl3_r.zero <= zero2_r;
    tu_r <= (TW'(pu_r) << OUT_BITS) - TW'(pu_r) + TW'(s2_r);
    tv_r <= (TW'(pv_r) << OUT_BITS) - TW'(pv_r) + TW'(s2_r);
    d_r  <= {s2_r, 1'b0};
  end

  assign ctl_o   = ctl3_r;
  assign top_u_o = tu_r;
  assign top_v_o = tv_r;
  assign den_o   = d_r;

endmodule

[src/onenc_div_stage.sv]
// ----------------------------------------------------------------------------
// Octahedral encoder divider stage
// One restoring-division step for both coordinates, producing one quotient bit.
// ----------------------------------------------------------------------------
module onenc_div_stage #(
  parameter int TW  = 36,
  parameter int DW  = 19,
  parameter int QW  = 16,
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  onenc_pkg::onenc_ctl_t ctl_i,
  input  logic [TW-1:0]         rem_u_i,
  input  logic [TW-1:0]         rem_v_i,
  input  logic [QW-1:0]         q_u_i,
  input  logic [QW-1:0]         q_v_i,
  input  logic [DW-1:0]         den_i,
  output onenc_pkg::onenc_ctl_t ctl_o,
  output logic [TW-1:0]         rem_u_o,
  output logic [TW-1:0]         rem_v_o,
  output logic [QW-1:0]         q_u_o,
  output logic [QW-1:0]         q_v_o,
  output logic [DW-1:0]         den_o
);

  onenc_pkg::onenc_ctl_t ctl_r;
  logic [TW-1:0] rem_u_r, rem_v_r;
  logic [QW-1:0] q_u_r, q_v_r;
  logic [DW-1:0] den_r;
  logic [TW-1:0] dsh;
  logic          ge_u, ge_v;

  always_comb begin
    dsh  = TW'(den_i) << BIT;
    ge_u = (rem_u_i >= dsh);
    ge_v = (rem_v_i >= dsh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.zero <= ctl_i.zero;
    rem_u_r    <= ge_u ? rem_u_i - dsh : rem_u_i;
    rem_v_r    <= ge_v ? rem_v_i - dsh : rem_v_i;
    q_u_r      <= q_u_i | (QW'(ge_u) << BIT);
    q_v_r      <= q_v_i | (QW'(ge_v) << BIT);
    den_r      <= den_i;
  end

  assign ctl_o   = ctl_r;
  assign rem_u_o = rem_u_r;
  assign rem_v_o = rem_v_r;
  assign q_u_o   = q_u_r;
  assign q_v_o   = q_v_r;
  assign den_o   = den_r;

endmodule
